// ===== design/per_key_write_rate_monitor_defines.svh =====
// ---------------------------------------------------------------------------
// Per-key write rate monitor: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PER_KEY_WRITE_RATE_MONITOR_DEFINES_SVH
`define PER_KEY_WRITE_RATE_MONITOR_DEFINES_SVH

// same-cycle implication
`define PKWRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKWRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pkwrm_pkg.sv =====
// ---------------------------------------------------------------------------
// Per-key write rate monitor: package
// Types, codes and constants shared by the front, the engine and the top.
// ---------------------------------------------------------------------------
package pkwrm_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [31:0] WINDOW_RESET = 32'd10000;
  localparam logic [15:0] THRESH_RESET = 16'd50;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd1;

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_RESET  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RECORD,
    OP_RESET,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] pid;
    logic [47:0] now;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t item;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } eng_ctl_t;

  typedef struct packed {
    logic [31:0] window;
    logic [15:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [31:0] proc;
    logic [15:0] count;
    logic [47:0] start;
    logic        flag;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SEL,
    ST_EVAL,
    ST_EXEC
  } eng_state_t;

endpackage

// ===== design/per_key_write_rate_monitor.sv =====
// ---------------------------------------------------------------------------
// Per-key write rate monitor: top level
// Counts document writes per process id in fixed windows and flags bursts.
// ---------------------------------------------------------------------------
// Channels: request beats on in_* (type, process id, document bit, time in
// ms), one result beat on out_* (flagged) per request, in request order.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. Registers window_ms (index 0) and file_threshold (index 1) are
// written on cfg_* whenever cfg_valid is high; cfg_ready is always high.
// Each record, reset or query passes through the engine's scan, drain,
// select, window compare and write-back steps; the scan reads the slot
// table one entry per cycle through its single read port. Requests that
// touch no slot go straight from idle to write-back. out_valid is
// registered from the write-back step, and a stalled result beat holds.
// A 4-entry request queue keeps in_stall low while a result waits.
// Reset: a clearing pass writes zeroes to every table entry; in_stall stays
// high meanwhile. A stalled result holds the engine once it has the next
// result ready; the queue keeps accepting until full.
// ---------------------------------------------------------------------------
module per_key_write_rate_monitor import pkwrm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [31:0]          in_proc_id,
  input  logic                 in_is_document,
  input  logic [47:0]          in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_flagged,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t     cfg_r;
  eng_ctl_t ctl;
  head_t    q_hd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window    <= WINDOW_RESET;
      cfg_r.threshold <= THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW:    cfg_r.window    <= cfg_data;
        CFG_THRESHOLD: cfg_r.threshold <= cfg_data[15:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  pkwrm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_proc_id     (in_proc_id),
    .in_is_document (in_is_document),
    .in_now_ms      (in_now_ms),
    .ctl            (ctl),
    .q_hd           (q_hd)
  );

  pkwrm_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_hd        (q_hd),
    .ctl         (ctl),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_flagged (out_flagged)
  );

endmodule

// ===== design/pkwrm_front.sv =====
// ---------------------------------------------------------------------------
// Per-key write rate monitor: front end
// Accepts request beats, classifies them and queues them for the engine.
// ---------------------------------------------------------------------------
module pkwrm_front import pkwrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_proc_id,
  input  logic        in_is_document,
  input  logic [47:0] in_now_ms,
  input  eng_ctl_t    ctl,
  output head_t       q_hd
);

  req_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  req_t              cls;

  always_comb begin
    cls.pid = in_proc_id;
    cls.now = in_now_ms;
    unique case (in_req_type)
      REQ_RECORD: cls.op = (in_proc_id != '0 && in_is_document) ? OP_RECORD : OP_NONE;
      REQ_RESET:  cls.op = (in_proc_id != '0) ? OP_RESET : OP_NONE;
      REQ_QUERY:  cls.op = (in_proc_id != '0) ? OP_QUERY : OP_NONE;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH)) || ctl.clearing;
  assign push     = in_valid && !in_stall;

  assign q_hd.valid = (cnt_r != '0);
  assign q_hd.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, ctl.pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== design/pkwrm_engine.sv =====
// ---------------------------------------------------------------------------
// Per-key write rate monitor: slot engine
// Clears the slot table, scans it per request and applies the update.
// ---------------------------------------------------------------------------
module pkwrm_engine import pkwrm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  head_t    q_hd,
  output eng_ctl_t ctl,
  input  logic     out_stall,
  output logic     out_valid,
  output logic     out_flagged
);

  `include "per_key_write_rate_monitor_defines.svh"

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  slot_t            mem [SLOTS];
  slot_t            rd_data_r;

  eng_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, scan_r, cmp_idx_r;
  logic             cmp_vld_r;
  req_t             cur_r;

  logic             hit_found_r, empty_found_r;
  logic [IDX_W-1:0] hit_idx_r, empty_idx_r;
  slot_t            hit_entry_r;

  logic             tgt_vld_r;
  logic [IDX_W-1:0] tgt_idx_r;
  slot_t            tgt_r;
  logic             expired_r;

  logic             out_valid_r, out_flagged_r;
  logic             out_free;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;

  logic             exec_wr, exec_res;
  slot_t            exec_data;
  logic [15:0]      cnt_inc;
  logic [47:0]      elapsed;

  assign out_free    = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_flagged = out_flagged_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_hd.valid) begin
          state_nxt = (q_hd.item.op == OP_NONE) ? ST_EXEC : ST_SCAN;
        end
      end
      ST_SCAN:  if (scan_r == LAST) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_SEL;
      ST_SEL:   state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_EXEC;
      ST_EXEC:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // update of the target slot
  always_comb begin
    cnt_inc   = (tgt_r.count == 16'hFFFF) ? tgt_r.count : tgt_r.count + 16'd1;
    exec_wr   = 1'b0;
    exec_res  = 1'b0;
    exec_data = tgt_r;
    unique case (cur_r.op)
      OP_RECORD: begin
        if (tgt_vld_r) begin
          exec_wr = 1'b1;
          if (expired_r) begin
            exec_data.count = 16'd1;
            exec_data.start = cur_r.now;
            exec_data.flag  = 1'b0;
          end else if (tgt_r.flag) begin
            exec_res = 1'b1;
          end else begin
            exec_data.count = cnt_inc;
            if (cnt_inc >= cfg.threshold) begin
              exec_data.flag = 1'b1;
              exec_res       = 1'b1;
            end
          end
        end
      end
      OP_RESET: begin
        if (tgt_vld_r) begin
          exec_wr         = 1'b1;
          exec_data.proc  = '0;
          exec_data.count = '0;
          exec_data.flag  = 1'b0;
        end
      end
      OP_QUERY: begin
        if (tgt_vld_r && tgt_r.flag) begin
          if (!expired_r) begin
            exec_res = 1'b1;
          end else begin
            exec_wr         = 1'b1;
            exec_data.count = '0;
            exec_data.flag  = 1'b0;
          end
        end
      end
      OP_NONE: begin
        exec_wr = 1'b0;
      end
    endcase
  end

  // outputs
  always_comb begin
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = tgt_idx_r;
    wr_data      = exec_data;
    ctl.pop      = 1'b0;
    ctl.clearing = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_r;
        wr_data      = '0;
        ctl.clearing = 1'b1;
      end
      ST_IDLE:  ctl.pop = q_hd.valid;
      ST_SCAN:  rd_en = 1'b1;
      ST_EXEC:  wr_en = exec_wr && out_free;
      default:  rd_en = 1'b0;
    endcase
  end

  assign elapsed = (cur_r.now >= tgt_r.start) ? cur_r.now - tgt_r.start : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      scan_r        <= '0;
      cmp_vld_r     <= 1'b0;
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= rd_en;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (ctl.pop) begin
        scan_r        <= '0;
        hit_found_r   <= 1'b0;
        empty_found_r <= 1'b0;
      end else if (rd_en) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmp_vld_r) begin
        if (!hit_found_r && rd_data_r.proc == cur_r.pid) begin
          hit_found_r <= 1'b1;
        end
        if (!empty_found_r && rd_data_r.proc == '0) begin
          empty_found_r <= 1'b1;
        end
      end
      if (state_r == ST_EXEC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_r <= q_hd.item;
    end
    cmp_idx_r <= scan_r;
    if (cmp_vld_r) begin
      if (!hit_found_r && rd_data_r.proc == cur_r.pid) begin
        hit_idx_r   <= cmp_idx_r;
        hit_entry_r <= rd_data_r;
      end
      if (!empty_found_r && rd_data_r.proc == '0) begin
        empty_idx_r <= cmp_idx_r;
      end
    end
    if (state_r == ST_SEL) begin
      if (hit_found_r) begin
        tgt_vld_r <= 1'b1;
        tgt_idx_r <= hit_idx_r;
        tgt_r     <= hit_entry_r;
      end else if (cur_r.op == OP_RECORD && empty_found_r) begin
        tgt_vld_r <= 1'b1;
        tgt_idx_r <= empty_idx_r;
        tgt_r     <= '{proc: cur_r.pid, count: '0, start: cur_r.now, flag: 1'b0};
      end else begin
        tgt_vld_r <= 1'b0;
      end
    end
    if (state_r == ST_EVAL) begin
      expired_r <= elapsed >= {16'd0, cfg.window};
    end
    if (state_r == ST_EXEC && out_free) begin
      out_flagged_r <= exec_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[scan_r];
    end
  end

  `PKWRM_ASSERT_SAME(a_pop_has_item, ctl.pop, q_hd.valid, "pop from empty queue")
  `PKWRM_ASSERT_SAME(a_hit_empty_apart, hit_found_r && empty_found_r,
                     hit_idx_r != empty_idx_r, "hit and empty slot coincide")
  `PKWRM_ASSERT_NEXT(a_result_held, out_valid_r && out_stall,
                     out_valid_r && $stable(out_flagged_r), "stalled result lost")
  `PKWRM_ASSERT_SAME(a_no_rw_clash, rd_en, !wr_en, "table read during write")

endmodule
